### hdl/eigenvalue_sign_stats_check_core_assert.svh
// Assertion macros for the eigenvalue sign statistics check core
`ifndef EIGENVALUE_SIGN_STATS_CHECK_CORE_ASSERT_SVH
`define EIGENVALUE_SIGN_STATS_CHECK_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define ESC_ASSERT_IMP(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ESC_ASSERT_NXT(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

### hdl/esc_pkg.sv
// Shared types and constants for the eigenvalue sign statistics check
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned SUM_WIDTH_DEF   = 48;

  // ratio tolerance is unsigned Q8.16
  localparam int unsigned TOL_W    = 24;
  localparam int unsigned TOL_FRAC = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 24'd655;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = TOL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRUNC_MODE = 1'b0,
    CFG_RATIO_TOL  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    TRUNC_ZERO = 1'b0,
    TRUNC_ABS  = 1'b1
  } trunc_mode_e;

  // control for one step of the set accumulator
  typedef struct packed {
    logic load;
    logic last;
  } step_ctl_t;

endpackage

`default_nettype wire

### hdl/esc_accum.sv
// Set accumulator: truncation, min/max tracking and saturating sign sums
`timescale 1ns / 1ps
`default_nettype none

module esc_accum #(
  parameter int unsigned VALUE_WIDTH = esc_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned SUM_WIDTH   = esc_pkg::SUM_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  esc_pkg::step_ctl_t            ctl_i,
  input  esc_pkg::trunc_mode_e          mode_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic        [VALUE_WIDTH-2:0] trunc_o,
  output logic signed [VALUE_WIDTH-1:0] min_o,
  output logic        [VALUE_WIDTH-2:0] max_o,
  output logic        [SUM_WIDTH-2:0]   pos_o,
  output logic        [SUM_WIDTH-1:0]   neg_o
);

  localparam int unsigned ACC_W = ((SUM_WIDTH > VALUE_WIDTH) ? SUM_WIDTH : VALUE_WIDTH) + 1;
  localparam logic [SUM_WIDTH-2:0] POS_MAX = '1;
  localparam logic [SUM_WIDTH-1:0] NEG_MAX = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-2:0] TRUNC_MAX = '1;

  logic signed [VALUE_WIDTH-1:0] min_q, min_d;
  logic        [VALUE_WIDTH-2:0] max_q, max_d;
  logic        [SUM_WIDTH-2:0]   pos_q, pos_d;
  logic        [SUM_WIDTH-1:0]   neg_q, neg_d;

  logic [VALUE_WIDTH-1:0] val_u;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   is_pos;
  logic [ACC_W-1:0]       pos_sum;
  logic [ACC_W-1:0]       neg_sum;

  assign val_u  = value_i;
  assign is_pos = !val_u[VALUE_WIDTH-1] && (|val_u);
  // magnitude; the most negative value maps to 2^(VALUE_WIDTH-1)
  assign mag    = is_pos ? val_u : (VALUE_WIDTH'(0) - val_u);

  assign pos_sum = ACC_W'(pos_q) + ACC_W'(mag);
  assign neg_sum = ACC_W'(neg_q) + ACC_W'(mag);

  always_comb begin
    if (is_pos) begin
      trunc_o = mag[VALUE_WIDTH-2:0];
    end else if (mode_i == esc_pkg::TRUNC_ABS) begin
      trunc_o = mag[VALUE_WIDTH-1] ? TRUNC_MAX : mag[VALUE_WIDTH-2:0];
    end else begin
      trunc_o = '0;
    end

    min_d = (value_i < min_q) ? value_i : min_q;
    max_d = (is_pos && (val_u[VALUE_WIDTH-2:0] > max_q)) ? val_u[VALUE_WIDTH-2:0] : max_q;

    pos_d = pos_q;
    neg_d = neg_q;
    if (is_pos) begin
      pos_d = (pos_sum > ACC_W'(POS_MAX)) ? POS_MAX : pos_sum[SUM_WIDTH-2:0];
    end else begin
      neg_d = (neg_sum > ACC_W'(NEG_MAX)) ? NEG_MAX : neg_sum[SUM_WIDTH-1:0];
    end
  end

  assign min_o = min_d;
  assign max_o = max_d;
  assign pos_o = pos_d;
  assign neg_o = neg_d;

  // state clears once the last word of a set has been folded in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '0;
      pos_q <= '0;
      neg_q <= '0;
    end else if (ctl_i.load) begin
      if (ctl_i.last) begin
        min_q <= '0;
        max_q <= '0;
        pos_q <= '0;
        neg_q <= '0;
      end else begin
        min_q <= min_d;
        max_q <= max_d;
        pos_q <= pos_d;
        neg_q <= neg_d;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/esc_ratio_chk.sv
// Tolerance check |neg| * 2^16 > tol * pos with a split, registered multiply
`timescale 1ns / 1ps
`default_nettype none

module esc_ratio_chk #(
  parameter int unsigned SUM_WIDTH = esc_pkg::SUM_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic [esc_pkg::TOL_W-1:0] tol_i,
  input  logic [SUM_WIDTH-2:0]      pos_i,
  input  logic [SUM_WIDTH-1:0]      neg_i,
  output logic                      viol_o
);

  localparam int unsigned POS_W = SUM_WIDTH - 1;
  localparam int unsigned LO_W  = POS_W / 2;
  localparam int unsigned HI_W  = POS_W - LO_W;
  localparam int unsigned CMP_W = esc_pkg::TOL_W + POS_W;

  logic [esc_pkg::TOL_W+LO_W-1:0] pp_lo_q, pp_lo_d;
  logic [esc_pkg::TOL_W+HI_W-1:0] pp_hi_q, pp_hi_d;
  logic [CMP_W-1:0]               prod;
  logic [CMP_W-1:0]               lhs;

  assign pp_lo_d = (esc_pkg::TOL_W+LO_W)'(tol_i) * (esc_pkg::TOL_W+LO_W)'(pos_i[LO_W-1:0]);
  assign pp_hi_d = (esc_pkg::TOL_W+HI_W)'(tol_i) * (esc_pkg::TOL_W+HI_W)'(pos_i[POS_W-1:LO_W]);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pp_lo_q <= pp_lo_d;
      pp_hi_q <= pp_hi_d;
    end
  end

  // a zero positive sum flags any nonzero negative sum, as the product is zero
  assign prod   = CMP_W'({pp_hi_q, {LO_W{1'b0}}}) + CMP_W'(pp_lo_q);
  assign lhs    = CMP_W'({neg_i, {esc_pkg::TOL_FRAC{1'b0}}});
  assign viol_o = lhs > prod;

endmodule

`default_nettype wire

### hdl/eigenvalue_sign_stats_check_core.sv
// Eigenvalue sign statistics check: top level with pipeline and config registers
//
// Input channel (in_valid_i/in_ready_o) takes one signed eigenvalue word per
// cycle while in_ready_o is high, with end_of_set_i high on the last word of a set.
// Output channel (out_valid_o/out_ready_i) gives one result word per input word: the
// truncated value, plus on the last word of a set the min, max, both sums and
// the tolerance flag (all zero on other words).
// Pipeline: input register, accumulate, partial products, result register.
// One word per cycle is sustained while the receiver takes results, set by the
// single accumulate stage that folds each word in.
// When the receiver stalls the four stages fill and in_ready_o drops only
// once every stage holds a word; it rises again in the cycle output is taken.
// Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) is written by the user only while idle;
// the block does not enforce it. Reset empties the pipeline, clears the set statistics,
// sets truncate mode to zero-clamp and the ratio tolerance to 655 (about 0.01 in Q8.16).
`timescale 1ns / 1ps
`default_nettype none
`include "eigenvalue_sign_stats_check_core_assert.svh"

module eigenvalue_sign_stats_check_core #(
  parameter int unsigned VALUE_WIDTH = esc_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned SUM_WIDTH   = esc_pkg::SUM_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [esc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [esc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0]  eigen_value_i,
  input  logic                           end_of_set_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic        [VALUE_WIDTH-2:0]  truncated_value_o,
  output logic                           set_done_o,
  output logic signed [VALUE_WIDTH-1:0]  most_negative_o,
  output logic        [VALUE_WIDTH-2:0]  most_positive_o,
  output logic        [SUM_WIDTH-2:0]    positive_total_o,
  output logic signed [SUM_WIDTH-1:0]    negative_total_o,
  output logic                           tolerance_violated_o
);

  // configuration
  esc_pkg::trunc_mode_e      mode_q;
  logic [esc_pkg::TOL_W-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= esc_pkg::TRUNC_ZERO;
      tol_q  <= esc_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      unique case (esc_pkg::cfg_idx_e'(cfg_idx_i))
        esc_pkg::CFG_TRUNC_MODE: mode_q <= esc_pkg::trunc_mode_e'(cfg_data_i[0]);
        esc_pkg::CFG_RATIO_TOL:  tol_q  <= cfg_data_i[esc_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline valids and enables
  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q;
  logic a_en, b_en, c_en, d_en;
  logic b_adv;

  assign d_en  = !d_vld_q || out_ready_i;
  assign c_en  = !c_vld_q || (d_en && c_vld_q);
  assign b_en  = !b_vld_q || (c_en && b_vld_q);
  assign a_en  = !a_vld_q || (b_en && a_vld_q);
  assign b_adv = a_vld_q && b_en;

  assign in_ready_o  = a_en;
  assign out_valid_o = d_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      if (a_en) begin
        a_vld_q <= in_valid_i;
      end
      if (b_en) begin
        b_vld_q <= a_vld_q;
      end
      if (c_en) begin
        c_vld_q <= b_vld_q;
      end
      if (d_en) begin
        d_vld_q <= c_vld_q;
      end
    end
  end

  // stage A: input register
  logic signed [VALUE_WIDTH-1:0] a_val_q;
  logic                          a_last_q;

  always_ff @(posedge clk_i) begin
    if (a_en) begin
      a_val_q  <= eigen_value_i;
      a_last_q <= end_of_set_i;
    end
  end

  // stage B: accumulate
  esc_pkg::step_ctl_t            acc_ctl;
  logic        [VALUE_WIDTH-2:0] acc_trunc;
  logic signed [VALUE_WIDTH-1:0] acc_min;
  logic        [VALUE_WIDTH-2:0] acc_max;
  logic        [SUM_WIDTH-2:0]   acc_pos;
  logic        [SUM_WIDTH-1:0]   acc_neg;

  assign acc_ctl.load = b_adv;
  assign acc_ctl.last = a_last_q;

  esc_accum #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .SUM_WIDTH  (SUM_WIDTH)
  ) u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (acc_ctl),
    .mode_i (mode_q),
    .value_i(a_val_q),
    .trunc_o(acc_trunc),
    .min_o  (acc_min),
    .max_o  (acc_max),
    .pos_o  (acc_pos),
    .neg_o  (acc_neg)
  );

  logic        [VALUE_WIDTH-2:0] b_trunc_q;
  logic                          b_last_q;
  logic signed [VALUE_WIDTH-1:0] b_min_q;
  logic        [VALUE_WIDTH-2:0] b_max_q;
  logic        [SUM_WIDTH-2:0]   b_pos_q;
  logic        [SUM_WIDTH-1:0]   b_neg_q;

  always_ff @(posedge clk_i) begin
    if (b_en) begin
      b_trunc_q <= acc_trunc;
      b_last_q  <= a_last_q;
      b_min_q   <= acc_min;
      b_max_q   <= acc_max;
      b_pos_q   <= acc_pos;
      b_neg_q   <= acc_neg;
    end
  end

  // stage C: partial products of tol * pos
  logic        [VALUE_WIDTH-2:0] c_trunc_q;
  logic                          c_last_q;
  logic signed [VALUE_WIDTH-1:0] c_min_q;
  logic        [VALUE_WIDTH-2:0] c_max_q;
  logic        [SUM_WIDTH-2:0]   c_pos_q;
  logic        [SUM_WIDTH-1:0]   c_neg_q;
  logic                          c_viol;

  always_ff @(posedge clk_i) begin
    if (c_en) begin
      c_trunc_q <= b_trunc_q;
      c_last_q  <= b_last_q;
      c_min_q   <= b_min_q;
      c_max_q   <= b_max_q;
      c_pos_q   <= b_pos_q;
      c_neg_q   <= b_neg_q;
    end
  end

  esc_ratio_chk #(
    .SUM_WIDTH(SUM_WIDTH)
  ) u_ratio_chk (
    .clk_i (clk_i),
    .load_i(c_en),
    .tol_i (tol_q),
    .pos_i (b_pos_q),
    .neg_i (c_neg_q),
    .viol_o(c_viol)
  );

  // stage D: result register; statistics only on the last word of a set
  logic        [VALUE_WIDTH-2:0] out_trunc_q;
  logic                          out_done_q;
  logic signed [VALUE_WIDTH-1:0] out_min_q;
  logic        [VALUE_WIDTH-2:0] out_max_q;
  logic        [SUM_WIDTH-2:0]   out_pos_q;
  logic signed [SUM_WIDTH-1:0]   out_neg_q;
  logic                          out_viol_q;

  always_ff @(posedge clk_i) begin
    if (d_en) begin
      out_trunc_q <= c_trunc_q;
      out_done_q  <= c_last_q;
      out_min_q   <= c_last_q ? c_min_q : '0;
      out_max_q   <= c_last_q ? c_max_q : '0;
      out_pos_q   <= c_last_q ? c_pos_q : '0;
      out_neg_q   <= c_last_q ? signed'(SUM_WIDTH'(0) - c_neg_q) : '0;
      out_viol_q  <= c_last_q && c_viol;
    end
  end

  assign truncated_value_o    = out_trunc_q;
  assign set_done_o           = out_done_q;
  assign most_negative_o      = out_min_q;
  assign most_positive_o      = out_max_q;
  assign positive_total_o     = out_pos_q;
  assign negative_total_o     = out_neg_q;
  assign tolerance_violated_o = out_viol_q;

  // input only backs up when every stage is full and the output is stalled
  `ESC_ASSERT_IMP(a_stall_only_when_full, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i, "input stalled while result side free")
  `ESC_ASSERT_NXT(a_stall_keeps_word, clk_i, rst_ni, !in_ready_o, out_valid_o, "result word lost during stall")
  `ESC_ASSERT_IMP(a_zero_pos_flag, clk_i, rst_ni, out_valid_o && set_done_o && (positive_total_o == '0), tolerance_violated_o == (negative_total_o != '0), "flag wrong for zero positive sum")
  `ESC_ASSERT_IMP(a_neg_total_sign, clk_i, rst_ni, out_valid_o && set_done_o, (negative_total_o == '0) || negative_total_o[SUM_WIDTH-1], "negative sum above zero")

endmodule

`default_nettype wire
